// ----- rtl/ps2h_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2h_pkg
// shared types, codes and constants of the ps/2 host line transceiver
// ----------------------------------------------------------------------------
`default_nettype none

package ps2h_pkg;

	// phase timer width and the width of the timing registers
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

	localparam count_t COUNT_MAX = '1;

	// request codes carried by the mode field
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SEND = 2'd1;
	localparam logic [1:0] MODE_RECV = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_GAP     = 2'd0;
	localparam logic [1:0] CFG_INHIBIT = 2'd1;
	localparam logic [1:0] CFG_REQUEST = 2'd2;
	localparam logic [1:0] CFG_SETTLE  = 2'd3;

	// reset values of the timing registers
	localparam cfg_word_t GAP_RESET     = 16'd300;
	localparam cfg_word_t INHIBIT_RESET = 16'd300;
	localparam cfg_word_t REQUEST_RESET = 16'd10;
	localparam cfg_word_t SETTLE_RESET  = 16'd50;

	// frame bit counts
	localparam logic [3:0] DATA_BITS = 4'd8;
	localparam logic [3:0] TAIL_EDGES = 4'd4;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_TX_GAP,
		PH_TX_INHIBIT,
		PH_TX_REQUEST,
		PH_TX_FIRST_LOW,
		PH_TX_BIT_HIGH,
		PH_TX_BIT_LOW,
		PH_TX_SETTLE,
		PH_TX_ACK_LOW,
		PH_TX_ACK_HIGH,
		PH_RX_SETTLE,
		PH_RX_START_LOW,
		PH_RX_START_HIGH,
		PH_RX_BIT_LOW,
		PH_RX_BIT_HIGH,
		PH_RX_TAIL
	} phase_t;

	typedef struct packed {
		cfg_word_t gap;
		cfg_word_t inhibit;
		cfg_word_t request;
		cfg_word_t settle;
	} cfg_t;

	typedef struct packed {
		logic       clk_low;
		logic       data_low;
		logic       busy;
		logic       tx_done;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/ps2h_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ps2h_cfg_regs
// timing registers of the transceiver, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module ps2h_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire ps2h_pkg::cfg_word_t cfg_wdata,
	output ps2h_pkg::cfg_t           cfg
);

	ps2h_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap     <= ps2h_pkg::GAP_RESET;
			cfg_q.inhibit <= ps2h_pkg::INHIBIT_RESET;
			cfg_q.request <= ps2h_pkg::REQUEST_RESET;
			cfg_q.settle  <= ps2h_pkg::SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ps2h_pkg::CFG_GAP:     cfg_q.gap     <= cfg_wdata;
				ps2h_pkg::CFG_INHIBIT: cfg_q.inhibit <= cfg_wdata;
				ps2h_pkg::CFG_REQUEST: cfg_q.request <= cfg_wdata;
				ps2h_pkg::CFG_SETTLE:  cfg_q.settle  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/ps2h_fsm.sv -----
// ----------------------------------------------------------------------------
// ps2h_fsm
// link sequencer: one step per accepted tick, result from the updated state
// ----------------------------------------------------------------------------
`default_nettype none

module ps2h_fsm (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire ps2h_pkg::cfg_t cfg,
	input  wire logic [1:0]     mode,
	input  wire logic [7:0]     tx_byte,
	input  wire logic           clk_in,
	input  wire logic           data_in,
	output ps2h_pkg::res_t      res
);

	ps2h_pkg::phase_t phase_q, phase_d;
	ps2h_pkg::count_t cnt_q, cnt_d, cnt_inc;
	logic [3:0]       bit_q, bit_d, bit_inc;
	logic [7:0]       shift_q, shift_d;
	logic             par_q, par_d;
	logic             tx_done_d, rx_valid_d;
	logic             tmr_gap, tmr_inhibit, tmr_request, tmr_settle;

	// saturating phase timer and its end conditions
	assign cnt_inc = (cnt_q != ps2h_pkg::COUNT_MAX) ? cnt_q + ps2h_pkg::count_t'(1) : cnt_q;
	assign bit_inc = bit_q + 4'd1;

	assign tmr_gap = (ps2h_pkg::CMP_WIDTH'(cnt_inc) >= ps2h_pkg::CMP_WIDTH'(cfg.gap))
		|| (cnt_inc == ps2h_pkg::COUNT_MAX);
	assign tmr_inhibit = (ps2h_pkg::CMP_WIDTH'(cnt_inc) >= ps2h_pkg::CMP_WIDTH'(cfg.inhibit))
		|| (cnt_inc == ps2h_pkg::COUNT_MAX);
	assign tmr_request = (ps2h_pkg::CMP_WIDTH'(cnt_inc) >= ps2h_pkg::CMP_WIDTH'(cfg.request))
		|| (cnt_inc == ps2h_pkg::COUNT_MAX);
	assign tmr_settle = (ps2h_pkg::CMP_WIDTH'(cnt_inc) >= ps2h_pkg::CMP_WIDTH'(cfg.settle))
		|| (cnt_inc == ps2h_pkg::COUNT_MAX);

	// next state
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		par_d      = par_q;
		tx_done_d  = 1'b0;
		rx_valid_d = 1'b0;
		case (phase_q)
			ps2h_pkg::PH_IDLE: begin
				if (mode == ps2h_pkg::MODE_SEND) begin
					shift_d = tx_byte;
					par_d   = 1'b1;
					bit_d   = '0;
					cnt_d   = '0;
					phase_d = ps2h_pkg::PH_TX_GAP;
				end else if (mode == ps2h_pkg::MODE_RECV) begin
					shift_d = '0;
					bit_d   = '0;
					cnt_d   = '0;
					phase_d = ps2h_pkg::PH_RX_SETTLE;
				end
			end
			ps2h_pkg::PH_TX_GAP: begin
				cnt_d = cnt_inc;
				if (tmr_gap) begin
					cnt_d   = '0;
					phase_d = ps2h_pkg::PH_TX_INHIBIT;
				end
			end
			ps2h_pkg::PH_TX_INHIBIT: begin
				cnt_d = cnt_inc;
				if (tmr_inhibit) begin
					cnt_d   = '0;
					phase_d = ps2h_pkg::PH_TX_REQUEST;
				end
			end
			ps2h_pkg::PH_TX_REQUEST: begin
				cnt_d = cnt_inc;
				if (tmr_request) begin
					cnt_d   = '0;
					phase_d = ps2h_pkg::PH_TX_FIRST_LOW;
				end
			end
			ps2h_pkg::PH_TX_FIRST_LOW: begin
				if (!clk_in) phase_d = ps2h_pkg::PH_TX_BIT_HIGH;
			end
			ps2h_pkg::PH_TX_BIT_HIGH: begin
				if (clk_in) phase_d = ps2h_pkg::PH_TX_BIT_LOW;
			end
			ps2h_pkg::PH_TX_BIT_LOW: begin
				if (!clk_in) begin
					if (bit_q < ps2h_pkg::DATA_BITS) begin
						par_d   = par_q ^ shift_q[0];
						shift_d = {1'b0, shift_q[7:1]};
						bit_d   = bit_inc;
						phase_d = ps2h_pkg::PH_TX_BIT_HIGH;
					end else begin
						cnt_d   = '0;
						phase_d = ps2h_pkg::PH_TX_SETTLE;
					end
				end
			end
			ps2h_pkg::PH_TX_SETTLE: begin
				cnt_d = cnt_inc;
				if (tmr_settle) phase_d = ps2h_pkg::PH_TX_ACK_LOW;
			end
			ps2h_pkg::PH_TX_ACK_LOW: begin
				if (!clk_in) phase_d = ps2h_pkg::PH_TX_ACK_HIGH;
			end
			ps2h_pkg::PH_TX_ACK_HIGH: begin
				if (clk_in && data_in) begin
					phase_d   = ps2h_pkg::PH_IDLE;
					tx_done_d = 1'b1;
				end
			end
			ps2h_pkg::PH_RX_SETTLE: begin
				cnt_d = cnt_inc;
				if (tmr_settle) phase_d = ps2h_pkg::PH_RX_START_LOW;
			end
			ps2h_pkg::PH_RX_START_LOW: begin
				if (!clk_in) phase_d = ps2h_pkg::PH_RX_START_HIGH;
			end
			ps2h_pkg::PH_RX_START_HIGH: begin
				if (clk_in) phase_d = ps2h_pkg::PH_RX_BIT_LOW;
			end
			ps2h_pkg::PH_RX_BIT_LOW: begin
				if (!clk_in) begin
					shift_d = {data_in, shift_q[7:1]};
					phase_d = ps2h_pkg::PH_RX_BIT_HIGH;
				end
			end
			ps2h_pkg::PH_RX_BIT_HIGH: begin
				if (clk_in) begin
					if (bit_inc >= ps2h_pkg::DATA_BITS) begin
						bit_d   = '0;
						phase_d = ps2h_pkg::PH_RX_TAIL;
					end else begin
						bit_d   = bit_inc;
						phase_d = ps2h_pkg::PH_RX_BIT_LOW;
					end
				end
			end
			ps2h_pkg::PH_RX_TAIL: begin
				// parity and stop: low, high, low, high
				if (bit_q[0] ? clk_in : !clk_in) begin
					if (bit_inc >= ps2h_pkg::TAIL_EDGES) begin
						bit_d      = '0;
						phase_d    = ps2h_pkg::PH_IDLE;
						rx_valid_d = 1'b1;
					end else begin
						bit_d = bit_inc;
					end
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// line drive and status from the state after the step
	always_comb begin
		res          = '0;
		res.busy     = (phase_d != ps2h_pkg::PH_IDLE);
		res.tx_done  = tx_done_d;
		res.rx_valid = rx_valid_d;
		res.rx_byte  = rx_valid_d ? shift_d : 8'd0;
		case (phase_d)
			ps2h_pkg::PH_IDLE,
			ps2h_pkg::PH_TX_INHIBIT: begin
				res.clk_low  = 1'b1;
				res.data_low = 1'b0;
			end
			ps2h_pkg::PH_TX_REQUEST: begin
				res.clk_low  = 1'b1;
				res.data_low = 1'b1;
			end
			ps2h_pkg::PH_TX_FIRST_LOW: begin
				res.clk_low  = 1'b0;
				res.data_low = 1'b1;
			end
			ps2h_pkg::PH_TX_BIT_HIGH,
			ps2h_pkg::PH_TX_BIT_LOW: begin
				res.clk_low  = 1'b0;
				res.data_low = (bit_d < ps2h_pkg::DATA_BITS) ? ~shift_d[0] : ~par_d;
			end
			default: begin
				res.clk_low  = 1'b0;
				res.data_low = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ps2h_pkg::PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			par_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			par_q   <= par_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ps2_host_line_transceiver.sv -----
// ----------------------------------------------------------------------------
// ps2_host_line_transceiver
// host side of the two-wire open-collector ps/2 link
// ----------------------------------------------------------------------------
// usage:
//   each input beat is one timer tick carrying the synchronized clock and
//   data line levels plus an optional request (send tx_byte, or receive);
//   requests are ignored while busy_res is high
//   each input beat produces exactly one output beat: line drive levels
//   (clk_low, data_low), busy_res, and the one-tick tx_done / rx_valid pulses
//   with rx_byte
//   the output beat is registered and presented in the cycle after the input
//   beat is accepted; one beat per cycle is sustained while out_stall is low,
//   limited only by the single sequencer step between state and output registers
//   stall: in_stall rises only when the output register holds a beat that is
//   being stalled; the sequencer then holds until that beat is taken
//   reset: timing registers return to their defaults (300, 300, 10, 50),
//   the sequencer sits idle, idle beats inhibit the clock, no output beat is pending
//   timing registers are written through cfg_we / cfg_index / cfg_wdata; the
//   block does not check its state, so the user must write them only while idle
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_host_line_transceiver (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration port
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire ps2h_pkg::cfg_word_t cfg_wdata,
	// tick input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [7:0]          tx_byte,
	input  wire logic                clk_in,
	input  wire logic                data_in,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     clk_low,
	output logic                     data_low,
	output logic                     busy_res,
	output logic                     tx_done,
	output logic                     rx_valid,
	output logic [7:0]               rx_byte
);

	ps2h_pkg::cfg_t cfg;
	ps2h_pkg::res_t res;
	ps2h_pkg::res_t res_q;
	logic           out_valid_q;
	logic           accept;

	// a pending output beat that is stalled blocks the next tick
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	ps2h_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ps2h_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.cfg     (cfg),
		.mode    (mode),
		.tx_byte (tx_byte),
		.clk_in  (clk_in),
		.data_in (data_in),
		.res     (res)
	);

	// output register: loads on every accepted tick, drains when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign clk_low   = res_q.clk_low;
	assign data_low  = res_q.data_low;
	assign busy_res  = res_q.busy;
	assign tx_done   = res_q.tx_done;
	assign rx_valid  = res_q.rx_valid;
	assign rx_byte   = res_q.rx_byte;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ps/2 host line transceiver: a device emulator
// walks the sampled clock and data lines through sends and receives, a
// predictor tracks the host sequencer tick by tick, and every result beat is
// compared field by field with the oldest predicted beat
// ----------------------------------------------------------------------------

module tb;
	import ps2h_pkg::*;

	// unused request code, the block treats it as a plain tick
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// cycles without any accepted beat before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// quiet cycles after the last expected beat
	localparam int SETTLE_CYCLES = 4;

	// one tick as the sender presents it
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] txb;
		logic       clk_s;
		logic       dat_s;
	} line_tick_t;

	// host sequencer predictor plus the store of beats it still owes
	class line_tracker;
		cfg_word_t  gap_len, inhibit_len, request_len, settle_len;
		phase_t     link_phase;
		count_t     phase_ticks;
		logic [3:0] bit_pos;
		logic [7:0] shifter;
		logic       odd_par;
		res_t       pending_beats[$];
		int         errors;
		int         beats_seen;

		function new();
			gap_len     = GAP_RESET;
			inhibit_len = INHIBIT_RESET;
			request_len = REQUEST_RESET;
			settle_len  = SETTLE_RESET;
			link_phase  = PH_IDLE;
			phase_ticks = '0;
			bit_pos     = '0;
			shifter     = '0;
			odd_par     = 1'b1;
			errors      = 0;
			beats_seen  = 0;
		endfunction

		function void set_reg(logic [1:0] idx, cfg_word_t value);
			case (idx)
				CFG_GAP:     gap_len = value;
				CFG_INHIBIT: inhibit_len = value;
				CFG_REQUEST: request_len = value;
				CFG_SETTLE:  settle_len = value;
				default: ;
			endcase
		endfunction

		function void start_phase(phase_t next_phase);
			link_phase  = next_phase;
			phase_ticks = '0;
		endfunction

		// counter saturates at all ones, which also ends the phase
		function bit timer_expired(cfg_word_t limit);
			if (phase_ticks != COUNT_MAX)
				phase_ticks = phase_ticks + 1'b1;
			return (phase_ticks >= limit) || (phase_ticks == COUNT_MAX);
		endfunction

		// one accepted tick: advance the sequencer and queue the beat it yields
		function void note_tick(line_tick_t t);
			res_t r;
			r = '0;
			case (link_phase)
				PH_IDLE: begin
					if (t.mode == MODE_SEND) begin
						shifter = t.txb;
						odd_par = 1'b1;
						bit_pos = '0;
						start_phase(PH_TX_GAP);
					end else if (t.mode == MODE_RECV) begin
						shifter = '0;
						bit_pos = '0;
						start_phase(PH_RX_SETTLE);
					end
				end
				PH_TX_GAP:     if (timer_expired(gap_len)) start_phase(PH_TX_INHIBIT);
				PH_TX_INHIBIT: if (timer_expired(inhibit_len)) start_phase(PH_TX_REQUEST);
				PH_TX_REQUEST: if (timer_expired(request_len)) start_phase(PH_TX_FIRST_LOW);
				PH_TX_FIRST_LOW: if (!t.clk_s) link_phase = PH_TX_BIT_HIGH;
				PH_TX_BIT_HIGH:  if (t.clk_s) link_phase = PH_TX_BIT_LOW;
				PH_TX_BIT_LOW: begin
					if (!t.clk_s) begin
						if (bit_pos < DATA_BITS) begin
							odd_par = odd_par ^ shifter[0];
							shifter = shifter >> 1;
							bit_pos++;
							link_phase = PH_TX_BIT_HIGH;
						end else begin
							start_phase(PH_TX_SETTLE);
						end
					end
				end
				PH_TX_SETTLE:  if (timer_expired(settle_len)) link_phase = PH_TX_ACK_LOW;
				PH_TX_ACK_LOW: if (!t.clk_s) link_phase = PH_TX_ACK_HIGH;
				PH_TX_ACK_HIGH: begin
					if (t.clk_s && t.dat_s) begin
						link_phase = PH_IDLE;
						r.tx_done  = 1'b1;
					end
				end
				PH_RX_SETTLE:     if (timer_expired(settle_len)) link_phase = PH_RX_START_LOW;
				PH_RX_START_LOW:  if (!t.clk_s) link_phase = PH_RX_START_HIGH;
				PH_RX_START_HIGH: if (t.clk_s) link_phase = PH_RX_BIT_LOW;
				PH_RX_BIT_LOW: begin
					if (!t.clk_s) begin
						shifter    = {t.dat_s, shifter[7:1]};
						link_phase = PH_RX_BIT_HIGH;
					end
				end
				PH_RX_BIT_HIGH: begin
					if (t.clk_s) begin
						bit_pos++;
						if (bit_pos >= DATA_BITS) begin
							bit_pos    = '0;
							link_phase = PH_RX_TAIL;
						end else begin
							link_phase = PH_RX_BIT_LOW;
						end
					end
				end
				default: begin
					// parity and stop: low, high, low, high
					if (bit_pos[0] ? t.clk_s : !t.clk_s) begin
						bit_pos++;
						if (bit_pos >= TAIL_EDGES) begin
							bit_pos    = '0;
							link_phase = PH_IDLE;
							r.rx_valid = 1'b1;
							r.rx_byte  = shifter;
						end
					end
				end
			endcase

			case (link_phase)
				PH_IDLE, PH_TX_INHIBIT: r.clk_low = 1'b1;
				PH_TX_REQUEST: begin
					r.clk_low  = 1'b1;
					r.data_low = 1'b1;
				end
				PH_TX_FIRST_LOW: r.data_low = 1'b1;
				PH_TX_BIT_HIGH, PH_TX_BIT_LOW:
					r.data_low = (bit_pos < DATA_BITS) ? ~shifter[0] : ~odd_par;
				default: ;
			endcase
			r.busy = (link_phase != PH_IDLE);
			pending_beats.push_back(r);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("beat %0d %s: expected %0h, got %0h", beats_seen, name, want, got);
			end
		endfunction

		function void check_beat(res_t got);
			res_t want;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("beat %0d: result with nothing pending", beats_seen);
				return;
			end
			want = pending_beats.pop_front();
			check_field("clk_low", 8'(want.clk_low), 8'(got.clk_low));
			check_field("data_low", 8'(want.data_low), 8'(got.data_low));
			check_field("busy_res", 8'(want.busy), 8'(got.busy));
			check_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
			check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
			check_field("rx_byte", want.rx_byte, got.rx_byte);
		endfunction
	endclass

	// ports of the block, all inputs known from time zero
	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_GAP;
	cfg_word_t  cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] mode = MODE_TICK;
	logic [7:0] tx_byte = '0;
	logic       clk_in = 1'b1;
	logic       data_in = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       clk_low;
	logic       data_low;
	logic       busy_res;
	logic       tx_done;
	logic       rx_valid;
	logic [7:0] rx_byte;

	line_tracker board;
	line_tick_t  scripted[$];        // directed ticks, consumed before random ones
	int          idle_pct = 0;       // sender idle chance per cycle
	int          stall_pct = 0;      // receiver stall chance per cycle
	int          quiet_cycles = 0;

	ps2_host_line_transceiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.tx_byte   (tx_byte),
		.clk_in    (clk_in),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.clk_low   (clk_low),
		.data_low  (data_low),
		.busy_res  (busy_res),
		.tx_done   (tx_done),
		.rx_valid  (rx_valid),
		.rx_byte   (rx_byte)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic line_tick_t line_tick(logic [1:0] m, logic [7:0] b, logic c, logic d);
		line_tick_t t;
		t.mode  = m;
		t.txb   = b;
		t.clk_s = c;
		t.dat_s = d;
		return t;
	endfunction

	// device emulator: leans toward the line level the host is waiting for,
	// so most ticks push the sequence forward; a few ticks are pure noise
	function automatic line_tick_t next_line_tick(bit allow_requests);
		line_tick_t t;
		int pick;
		if (scripted.size() != 0)
			return scripted.pop_front();
		t.mode  = 2'($urandom_range(0, 3));
		t.txb   = 8'($urandom_range(0, 255));
		t.clk_s = 1'($urandom_range(0, 1));
		t.dat_s = 1'($urandom_range(0, 1));
		// winding down: no new transfer once the budget is spent
		if (!allow_requests && board.link_phase == PH_IDLE) begin
			t.mode = MODE_TICK;
			return t;
		end
		if ($urandom_range(0, 99) < 8)
			return t;
		case (board.link_phase)
			PH_IDLE: begin
				pick = $urandom_range(0, 99);
				t.mode = (pick < 45) ? MODE_SEND : (pick < 90) ? MODE_RECV :
					(pick < 95) ? MODE_TICK : MODE_SPARE;
			end
			PH_TX_FIRST_LOW, PH_TX_BIT_LOW, PH_TX_ACK_LOW, PH_RX_START_LOW, PH_RX_BIT_LOW:
				t.clk_s = ($urandom_range(0, 2) == 0);
			PH_TX_BIT_HIGH, PH_RX_START_HIGH, PH_RX_BIT_HIGH:
				t.clk_s = ($urandom_range(0, 2) != 0);
			PH_TX_ACK_HIGH: begin
				if ($urandom_range(0, 2) != 0) begin
					t.clk_s = 1'b1;
					t.dat_s = 1'b1;
				end
			end
			PH_RX_TAIL:
				t.clk_s = ($urandom_range(0, 2) != 0) ? board.bit_pos[0] : ~board.bit_pos[0];
			default: ;   // timed phases ignore the lines
		endcase
		return t;
	endfunction

	// write all four timing registers, one beat per cycle, while idle
	task automatic load_timing(input cfg_word_t g, input cfg_word_t i,
			input cfg_word_t r, input cfg_word_t s);
		cfg_word_t  vals[4];
		logic [1:0] ids[4];
		vals = '{g, i, r, s};
		ids  = '{CFG_GAP, CFG_INHIBIT, CFG_REQUEST, CFG_SETTLE};
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= ids[k];
			cfg_wdata <= vals[k];
			@(posedge clk);
			board.set_reg(ids[k], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// present tick beats until the budget is spent and the link is idle again;
	// each next tick is drawn only after the previous one is accepted
	task automatic feed_ticks(input int budget);
		line_tick_t item;
		bit         holding;
		int         taken;
		taken   = 0;
		holding = 1'b0;
		while (taken < budget || board.link_phase != PH_IDLE) begin
			if (!holding && $urandom_range(0, 99) >= idle_pct) begin
				item     = next_line_tick(taken < budget);
				in_valid <= 1'b1;
				mode     <= item.mode;
				tx_byte  <= item.txb;
				clk_in   <= item.clk_s;
				data_in  <= item.dat_s;
				holding  = 1'b1;
			end else if (!holding) begin
				in_valid <= 1'b0;
			end
			@(posedge clk);
			if (in_valid && !in_stall) begin
				board.note_tick(item);
				taken++;
				holding = 1'b0;
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic run_setting(input cfg_word_t g, input cfg_word_t i, input cfg_word_t r,
			input cfg_word_t s, input int send_idle, input int recv_stall, input int budget);
		load_timing(g, i, r, s);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		feed_ticks(budget);
		while (board.pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: check accepted beats, stall at random, watch for a hang
	always @(posedge clk) begin : result_side
		bit moved;
		moved = 1'b0;
		if (out_valid && !out_stall) begin
			board.check_beat(res_t'({clk_low, data_low, busy_res, tx_done, rx_valid, rx_byte}));
			moved = 1'b1;
		end
		if (in_valid && !in_stall)
			moved = 1'b1;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] pattern;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the shortest timing: plain tick, spare code,
		// then one receive of a fixed byte with send requests thrown in while busy
		pattern = 8'hA5;
		scripted.push_back(line_tick(MODE_TICK, 8'h00, 1'b1, 1'b1));
		scripted.push_back(line_tick(MODE_SPARE, 8'hFF, 1'b0, 1'b0));
		scripted.push_back(line_tick(MODE_RECV, 8'h00, 1'b1, 1'b1));
		scripted.push_back(line_tick(MODE_SEND, 8'hFF, 1'b0, 1'b0));
		// start bit, caught straight away with no extra delay
		scripted.push_back(line_tick(MODE_SEND, 8'h00, 1'b0, 1'b0));
		scripted.push_back(line_tick(MODE_RECV, 8'hFF, 1'b1, 1'b1));
		for (int k = 0; k < 8; k++) begin
			scripted.push_back(line_tick(MODE_SEND, 8'hFF, 1'b0, pattern[k]));
			scripted.push_back(line_tick(MODE_SPARE, 8'h00, 1'b1, ~pattern[k]));
		end
		// parity and stop edges
		scripted.push_back(line_tick(MODE_TICK, 8'h00, 1'b0, 1'b1));
		scripted.push_back(line_tick(MODE_SEND, 8'h5A, 1'b1, 1'b0));
		scripted.push_back(line_tick(MODE_TICK, 8'h00, 1'b0, 1'b1));
		scripted.push_back(line_tick(MODE_RECV, 8'hFF, 1'b1, 1'b1));

		// zero limits: every timed phase lasts a single tick
		run_setting(16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 250);
		run_setting(cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 6)),
			cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 6)),
			76, 0, 250);
		run_setting(cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 6)),
			cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 6)),
			0, 76, 250);
		run_setting(cfg_word_t'($urandom_range(0, 3)), cfg_word_t'($urandom_range(0, 3)),
			cfg_word_t'($urandom_range(0, 3)), cfg_word_t'($urandom_range(0, 3)),
			35, 35, 250);
		run_setting(16'd3, 16'd0, 16'd1, 16'd2, 35, 35, 200);
		// back to the reset timing
		run_setting(GAP_RESET, INHIBIT_RESET, REQUEST_RESET, SETTLE_RESET, 35, 35, 150);

		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (board.errors == 0 && board.pending_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
